// ----- design/mpp_pkg.sv -----
`default_nettype none

package mpp_pkg;

  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_LENGTH  = 3'd1;
  localparam logic [2:0] KIND_TOPLEN  = 3'd2;
  localparam logic [2:0] KIND_TOPIC   = 3'd3;
  localparam logic [2:0] KIND_IDENT   = 3'd4;
  localparam logic [2:0] KIND_PAYLOAD = 3'd5;
  localparam logic [2:0] KIND_IGNORED = 3'd6;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_SHORT     = 2'd2;

  localparam logic [15:0] TOPIC_LIMIT_RESET = 16'd256;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       packet_start;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  byte_kind;
    logic [7:0]  data_byte;
    logic        topic_keep;
    logic        packet_done;
    logic [1:0]  status;
    logic [27:0] remaining_length;
    logic [1:0]  qos_level;
    logic [15:0] topic_length;
    logic [15:0] packet_ident;
    logic [27:0] payload_length;
  } out_beat_t;

  typedef struct packed {
    logic [2:0]  byte_kind;
    logic [7:0]  data_byte;
    logic        topic_keep;
    logic        packet_done;
    logic [1:0]  status;
    logic [27:0] remaining_length;
    logic [1:0]  qos_level;
    logic [15:0] topic_length;
    logic [15:0] packet_ident;
    logic        body_ge2;
  } cls_beat_t;

endpackage

`default_nettype wire

// ----- design/mpp_front.sv -----
`default_nettype none

module mpp_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire mpp_pkg::in_beat_t in_beat,
  input  wire logic              cfg_wr_en,
  input  wire logic [15:0]       cfg_wr_data,
  output mpp_pkg::cls_beat_t     cls_beat
);
  import mpp_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_LEN, PH_TLEN, PH_TOPIC, PH_ID, PH_PAYLOAD
  } phase_t;

  phase_t      phase_r, phase_nxt, phase_mid;
  logic [3:0]  flags_r, flags_nxt;
  logic [27:0] len_r, len_nxt;
  logic [2:0]  lcnt_r, lcnt_nxt;
  logic [27:0] body_r, body_nxt;
  logic [15:0] tlen_r, tlen_nxt;
  logic [15:0] ident_r, ident_nxt;
  logic        id_lo_r, id_lo_nxt;
  logic [15:0] limit_r;

  logic [7:0]  b;
  logic [27:0] shifted;
  logic [27:0] len_sum;
  logic [27:0] body_inc;
  logic [27:0] pos_m1;
  logic [15:0] tlen_lo;
  phase_t      after_topic;

  assign b        = in_beat.rx_byte;
  assign body_inc = body_r + 28'd1;
  assign pos_m1   = body_r - 28'd1;
  assign len_sum  = len_r + shifted;
  assign tlen_lo  = tlen_r | {8'd0, b};
  assign after_topic = (flags_r[2:1] != 2'd0) ? PH_ID : PH_PAYLOAD;

  always_comb begin
    case (lcnt_r[1:0])
      2'd0:    shifted = {21'd0, b[6:0]};
      2'd1:    shifted = {14'd0, b[6:0], 7'd0};
      2'd2:    shifted = {7'd0, b[6:0], 14'd0};
      default: shifted = {b[6:0], 21'd0};
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    phase_mid = phase_r;
    flags_nxt = flags_r;
    len_nxt   = len_r;
    lcnt_nxt  = lcnt_r;
    body_nxt  = body_r;
    tlen_nxt  = tlen_r;
    ident_nxt = ident_r;
    id_lo_nxt = id_lo_r;
    cls_beat.byte_kind   = KIND_IGNORED;
    cls_beat.topic_keep  = 1'b0;
    cls_beat.packet_done = 1'b0;
    cls_beat.status      = ST_OK;
    if (in_beat.packet_start) begin
      cls_beat.byte_kind = KIND_HEADER;
      flags_nxt = b[3:0];
      len_nxt   = '0;
      lcnt_nxt  = '0;
      body_nxt  = '0;
      tlen_nxt  = '0;
      ident_nxt = '0;
      id_lo_nxt = 1'b0;
      phase_nxt = PH_LEN;
    end else if (phase_r == PH_LEN) begin
      cls_beat.byte_kind = KIND_LENGTH;
      if (lcnt_r[2]) begin
        cls_beat.packet_done = 1'b1;
        cls_beat.status      = ST_MALFORMED;
        phase_nxt = PH_IDLE;
      end else begin
        len_nxt  = len_sum;
        lcnt_nxt = lcnt_r + 3'd1;
        if (!b[7]) begin
          if (len_sum == 28'd0) begin
            cls_beat.packet_done = 1'b1;
            cls_beat.status      = ST_SHORT;
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_TLEN;
          end
        end
      end
    end else if (phase_r != PH_IDLE) begin
      body_nxt = body_inc;
      case (phase_r)
        PH_TLEN: begin
          cls_beat.byte_kind = KIND_TOPLEN;
          if (body_r == 28'd0) begin
            tlen_nxt = {b, 8'd0};
          end else begin
            tlen_nxt  = tlen_lo;
            phase_mid = (tlen_lo != 16'd0) ? PH_TOPIC : after_topic;
          end
        end
        PH_TOPIC: begin
          cls_beat.byte_kind  = KIND_TOPIC;
          cls_beat.topic_keep = pos_m1 < {12'd0, limit_r};
          if (pos_m1 >= {12'd0, tlen_r}) begin
            phase_mid = after_topic;
          end
        end
        PH_ID: begin
          cls_beat.byte_kind = KIND_IDENT;
          if (!id_lo_r) begin
            ident_nxt = {b, 8'd0};
            id_lo_nxt = 1'b1;
          end else begin
            ident_nxt = ident_r | {8'd0, b};
            phase_mid = PH_PAYLOAD;
          end
        end
        default: begin
          cls_beat.byte_kind = KIND_PAYLOAD;
        end
      endcase
      phase_nxt = phase_mid;
      if (body_inc >= len_r) begin
        cls_beat.packet_done = 1'b1;
        cls_beat.status      = (phase_mid == PH_PAYLOAD) ? ST_OK : ST_SHORT;
        phase_nxt = PH_IDLE;
      end
    end
    cls_beat.data_byte        = b;
    cls_beat.remaining_length = len_nxt;
    cls_beat.qos_level        = flags_nxt[2:1];
    cls_beat.topic_length     = tlen_nxt;
    cls_beat.packet_ident     = ident_nxt;
    cls_beat.body_ge2         = |body_nxt[27:1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      flags_r <= '0;
      len_r   <= '0;
      lcnt_r  <= '0;
      body_r  <= '0;
      tlen_r  <= '0;
      ident_r <= '0;
      id_lo_r <= 1'b0;
      limit_r <= TOPIC_LIMIT_RESET;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (accept) begin
        phase_r <= phase_nxt;
        flags_r <= flags_nxt;
        len_r   <= len_nxt;
        lcnt_r  <= lcnt_nxt;
        body_r  <= body_nxt;
        tlen_r  <= tlen_nxt;
        ident_r <= ident_nxt;
        id_lo_r <= id_lo_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/mpp_fifo.sv -----
`default_nettype none

module mpp_fifo #(
  parameter int DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               wr_en,
  input  wire mpp_pkg::cls_beat_t wr_data,
  input  wire logic               rd_en,
  output mpp_pkg::cls_beat_t      rd_data,
  output logic                    full,
  output logic                    nonempty
);
  import mpp_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  cls_beat_t     slot_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign full     = cnt_r == CW'(DEPTH);
  assign nonempty = cnt_r != '0;
  assign rd_data  = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) begin
        wp_r <= (wp_r == LAST) ? '0 : wp_r + PW'(1);
      end
      if (rd_en) begin
        rp_r <= (rp_r == LAST) ? '0 : rp_r + PW'(1);
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (!wr_en && rd_en) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/mpp_back.sv -----
`default_nettype none

module mpp_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mpp_pkg::cls_beat_t cls_beat,
  input  wire logic               cls_avail,
  output logic                    cls_take,
  output mpp_pkg::out_beat_t      out_beat,
  output logic                    out_valid,
  input  wire logic               out_take
);
  import mpp_pkg::*;

  logic        valid_r;
  out_beat_t   beat_r, beat_nxt;
  logic [27:0] need;
  logic [27:0] pay;

  assign need = 28'd2 + {12'd0, cls_beat.topic_length}
              + ((cls_beat.qos_level != 2'd0) ? 28'd2 : 28'd0);
  assign pay  = (cls_beat.body_ge2 && cls_beat.remaining_length > need)
              ? cls_beat.remaining_length - need : 28'd0;

  assign cls_take  = cls_avail && (!valid_r || out_take);
  assign out_valid = valid_r;
  assign out_beat  = beat_r;

  always_comb begin
    beat_nxt.byte_kind        = cls_beat.byte_kind;
    beat_nxt.data_byte        = cls_beat.data_byte;
    beat_nxt.topic_keep       = cls_beat.topic_keep;
    beat_nxt.packet_done      = cls_beat.packet_done;
    beat_nxt.status           = cls_beat.status;
    beat_nxt.remaining_length = cls_beat.remaining_length;
    beat_nxt.qos_level        = cls_beat.qos_level;
    beat_nxt.topic_length     = cls_beat.topic_length;
    beat_nxt.packet_ident     = cls_beat.packet_ident;
    beat_nxt.payload_length   = pay;
  end

  always_ff @(posedge clk) begin
    if (cls_take) begin
      beat_r <= beat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cls_take) begin
      valid_r <= 1'b1;
    end else if (out_take) begin
      valid_r <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- design/mqtt_publish_packet_parser.sv -----
`default_nettype none

// Parser for MQTT PUBLISH packets, one received byte per beat, with one result beat per
// input beat. A beat with packet_start set is the fixed header and restarts the parse.
// Every byte is classified (header, length, topic length, topic, packet id, payload, or
// ignored) and carries the packet fields decoded so far. The front stage classifies the
// byte and updates the parse state in the cycle it is accepted. A QUEUE_DEPTH entry queue
// sits between the front stage and the output stage. The output stage computes the
// payload length into the output register. A byte is accepted every cycle while results
// are popped. A result is registered in the queue and then in the output register.
// cfg_wr_data sets the topic buffer size (reset 256). Write it only while the block is idle.
module mqtt_publish_packet_parser #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire mpp_pkg::in_beat_t  in_data,
  output logic                    empty,
  input  wire logic               pop,
  output mpp_pkg::out_beat_t      out_data,
  input  wire logic               cfg_wr_en,
  input  wire logic [15:0]        cfg_wr_data
);
  import mpp_pkg::*;

  cls_beat_t cls_in, cls_out;
  logic      accept;
  logic      q_full, q_avail, q_take;
  logic      out_valid;

  assign accept = push && !q_full;
  assign full   = q_full;
  assign empty  = !out_valid;

  mpp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_beat     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cls_beat    (cls_in)
  );

  mpp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (accept),
    .wr_data  (cls_in),
    .rd_en    (q_take),
    .rd_data  (cls_out),
    .full     (q_full),
    .nonempty (q_avail)
  );

  mpp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cls_beat  (cls_out),
    .cls_avail (q_avail),
    .cls_take  (q_take),
    .out_beat  (out_data),
    .out_valid (out_valid),
    .out_take  (pop)
  );

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
module tb;
  import mpp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD = 300;
  localparam int PHASE_BYTES = 165;

  typedef enum logic [2:0] {
    WAIT_START, IN_LENGTH, IN_TOPLEN, IN_TOPIC, IN_IDENT, IN_PAYLOAD
  } parse_st_t;

  logic clk = 1'b0;
  logic rst_n;
  logic push = 1'b0;
  logic full;
  in_beat_t in_data = '0;
  logic empty;
  logic pop = 1'b0;
  out_beat_t out_data;
  logic cfg_wr_en;
  logic [15:0] cfg_wr_data;

  in_beat_t rx_stream[$];
  out_beat_t parsed_beats[$];
  int queued_bytes = 0;
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;
  int hold_requests = 0;
  int holds_served = 0;

  parse_st_t parse_st = WAIT_START;
  logic [15:0] topic_limit_q = TOPIC_LIMIT_RESET;
  logic [3:0] hdr_flags = '0;
  logic [27:0] len_val = '0;
  logic [2:0] len_cnt = '0;
  logic [27:0] body_cnt = '0;
  logic [15:0] top_len = '0;
  logic [15:0] pkt_id = '0;

  mqtt_publish_packet_parser DUT (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_data(in_data),
    .empty(empty),
    .pop(pop),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #10 clk = ~clk;

  function automatic parse_st_t topic_next();
    return (hdr_flags[2:1] != 2'd0) ? IN_IDENT : IN_PAYLOAD;
  endfunction

  function automatic out_beat_t parse_byte(in_beat_t beat);
    out_beat_t r;
    logic [7:0] b;
    logic [31:0] pos;
    logic [31:0] tidx;
    logic [31:0] need;
    b = beat.rx_byte;
    r = '0;
    r.byte_kind = KIND_IGNORED;
    r.data_byte = b;
    if (beat.packet_start) begin
      r.byte_kind = KIND_HEADER;
      hdr_flags = b[3:0];
      len_val = '0;
      len_cnt = '0;
      body_cnt = '0;
      top_len = '0;
      pkt_id = '0;
      parse_st = IN_LENGTH;
    end else if (parse_st == IN_LENGTH) begin
      r.byte_kind = KIND_LENGTH;
      if (len_cnt >= 3'd4) begin
        r.packet_done = 1'b1;
        r.status = ST_MALFORMED;
        parse_st = WAIT_START;
      end else begin
        len_val = len_val + (28'(b[6:0]) << (7 * len_cnt));
        len_cnt = len_cnt + 3'd1;
        if (!b[7]) begin
          if (len_val == 28'd0) begin
            r.packet_done = 1'b1;
            r.status = ST_SHORT;
            parse_st = WAIT_START;
          end else begin
            parse_st = IN_TOPLEN;
          end
        end
      end
    end else if (parse_st != WAIT_START) begin
      pos = 32'(body_cnt);
      body_cnt = body_cnt + 28'd1;
      case (parse_st)
        IN_TOPLEN: begin
          r.byte_kind = KIND_TOPLEN;
          if (pos == 0) begin
            top_len = {b, 8'h00};
          end else begin
            top_len = top_len | 16'(b);
            parse_st = (top_len != 16'd0) ? IN_TOPIC : topic_next();
          end
        end
        IN_TOPIC: begin
          r.byte_kind = KIND_TOPIC;
          tidx = pos - 2;
          if (topic_limit_q != 16'd0 && tidx < 32'(topic_limit_q) - 1) r.topic_keep = 1'b1;
          if (tidx + 1 >= 32'(top_len)) parse_st = topic_next();
        end
        IN_IDENT: begin
          r.byte_kind = KIND_IDENT;
          if (pos - 2 - 32'(top_len) == 0) begin
            pkt_id = {b, 8'h00};
          end else begin
            pkt_id = pkt_id | 16'(b);
            parse_st = IN_PAYLOAD;
          end
        end
        default: r.byte_kind = KIND_PAYLOAD;
      endcase
      if (body_cnt >= len_val) begin
        r.packet_done = 1'b1;
        r.status = (parse_st == IN_PAYLOAD) ? ST_OK : ST_SHORT;
        parse_st = WAIT_START;
      end
    end
    if (body_cnt >= 28'd2) begin
      need = 2 + 32'(top_len) + ((hdr_flags[2:1] != 2'd0) ? 2 : 0);
      r.payload_length = (32'(len_val) > need) ? 28'(32'(len_val) - need) : 28'd0;
    end
    r.remaining_length = len_val;
    r.qos_level = hdr_flags[2:1];
    r.topic_length = top_len;
    r.packet_ident = pkt_id;
    return r;
  endfunction

  task automatic cmp_field(string name, logic [27:0] want, logic [27:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_beat(out_beat_t got);
    out_beat_t want;
    if (parsed_beats.size() == 0) begin
      errors++;
      $display("%0t: unexpected beat, expected none actual %h", $time, got);
    end else begin
      want = parsed_beats.pop_front();
      cmp_field("byte_kind", 28'(want.byte_kind), 28'(got.byte_kind));
      cmp_field("data_byte", 28'(want.data_byte), 28'(got.data_byte));
      cmp_field("topic_keep", 28'(want.topic_keep), 28'(got.topic_keep));
      cmp_field("packet_done", 28'(want.packet_done), 28'(got.packet_done));
      cmp_field("status", 28'(want.status), 28'(got.status));
      cmp_field("remaining_length", want.remaining_length, got.remaining_length);
      cmp_field("qos_level", 28'(want.qos_level), 28'(got.qos_level));
      cmp_field("topic_length", 28'(want.topic_length), 28'(got.topic_length));
      cmp_field("packet_ident", 28'(want.packet_ident), 28'(got.packet_ident));
      cmp_field("payload_length", want.payload_length, got.payload_length);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) parsed_beats.push_back(parse_byte(in_data));
      if (!push || !full) begin
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
          send_gap = $urandom_range(1, 16) - 1;
          push <= 1'b0;
        end else if (rx_stream.size() != 0) begin
          in_data <= rx_stream.pop_front();
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_beat(out_data);
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD - 1;
        pop <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        pop <= 1'b0;
      end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
        recv_gap = $urandom_range(1, 16) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic add_byte(logic [7:0] b, logic s);
    in_beat_t t;
    t.rx_byte = b;
    t.packet_start = s;
    rx_stream.push_back(t);
    queued_bytes++;
  endtask

  task automatic send_packet(logic [7:0] hdr, logic [27:0] rem, logic [15:0] tl, int body_n,
                             int pad);
    int groups;
    logic [27:0] v;
    add_byte(hdr, 1'b1);
    groups = 1;
    v = rem >> 7;
    while (v != 0) begin
      groups++;
      v = v >> 7;
    end
    groups = groups + pad;
    if (groups > 4) groups = 4;
    for (int k = 0; k < groups; k++)
      add_byte({k < groups - 1, 7'(rem >> (7 * k))}, 1'b0);
    for (int i = 0; i < body_n; i++)
      add_byte((i == 0) ? tl[15:8] : ((i == 1) ? tl[7:0] : 8'($urandom_range(0, 255))), 1'b0);
  endtask

  task automatic random_packet();
    logic [7:0] hdr;
    logic [15:0] tl;
    int pl;
    int full_len;
    int r;
    hdr = {($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'h3, 4'($urandom)};
    tl = ($urandom_range(0, 24) == 0) ? 16'($urandom_range(250, 300)) : 16'($urandom_range(0, 10));
    pl = ($urandom_range(0, 24) == 0) ? $urandom_range(100, 200) : $urandom_range(0, 12);
    full_len = 2 + tl + ((hdr[2:1] != 2'd0) ? 2 : 0) + pl;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      send_packet(hdr, 28'(full_len), tl, full_len, ($urandom_range(0, 9) == 0) ? 1 : 0);
    end else if (r < 75) begin
      pl = $urandom_range(0, full_len - 1);
      send_packet(hdr, 28'(pl), tl, pl, 0);
    end else if (r < 83) begin
      send_packet(hdr, 28'(full_len), tl, $urandom_range(0, full_len - 1), 0);
    end else if (r < 90) begin
      send_packet(hdr, 28'(full_len), tl, full_len + $urandom_range(1, 4), 0);
    end else if (r < 95) begin
      add_byte(hdr, 1'b1);
      repeat (4) add_byte(8'h80 | 8'($urandom), 1'b0);
      add_byte(8'($urandom), 1'b0);
    end else begin
      repeat ($urandom_range(1, 4)) add_byte(8'($urandom), $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic wait_drained();
    while (rx_stream.size() != 0 || push || parsed_beats.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(logic [15:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    topic_limit_q = v;
    @(negedge clk);
  endtask

  initial begin
    int target;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    target = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 15;
    recv_idle_pct = 15;
    add_byte(8'hFF, 1'b0);
    send_packet(8'h30, 28'd0, 16'd0, 0, 0);
    add_byte(8'h3B, 1'b1);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'h5A, 1'b0);
    send_packet(8'h36, 28'd5, 16'd0, 5, 0);
    send_packet(8'h32, 28'd3, 16'd2, 3, 0);
    send_packet(8'h3F, 28'hFFFFFFF, 16'hFFFF, 2, 0);

    for (int ph = 0; ph < 8; ph++) begin
      if (ph != 0) wait_drained();
      case (ph)
        1: begin write_limit(16'd0); send_idle_pct = 30; recv_idle_pct = 0; end
        2: begin
          write_limit(16'd1);
          send_idle_pct = 0;
          recv_idle_pct = 30;
          hold_requests <= hold_requests + 1;
        end
        3: begin write_limit(16'd2); send_idle_pct = 10; recv_idle_pct = 10; end
        4: begin write_limit(16'hFFFF); send_idle_pct = 20; recv_idle_pct = 20; end
        5: begin write_limit(16'($urandom_range(3, 300))); send_idle_pct = 0; recv_idle_pct = 0; end
        6: begin write_limit(16'd5); send_idle_pct = 25; recv_idle_pct = 25; end
        7: begin write_limit(16'd3); send_idle_pct = 0; recv_idle_pct = 0; end
        default: ;
      endcase
      target = target + PHASE_BYTES;
      while (queued_bytes < target) random_packet();
    end

    wait_drained();
    repeat (8) @(negedge clk);
    if (parsed_beats.size() != 0) errors++;
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ----- mqtt_publish_packet_parser.f -----
design/mpp_pkg.sv
design/mpp_front.sv
design/mpp_fifo.sv
design/mpp_back.sv
design/mqtt_publish_packet_parser.sv
bench/tb.sv
